// File: rtl/pixel_run_block_encoder_assert.svh
// Assertion macros shared by the pixel run block encoder checker.
// Depends on nothing; the user supplies clock, reset and expressions.
`ifndef PIXEL_RUN_BLOCK_ENCODER_ASSERT_SVH
`define PIXEL_RUN_BLOCK_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define PRBE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prbe: same-cycle check failed");

// Next-cycle implication.
`define PRBE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prbe: next-cycle check failed");

`endif

// File: rtl/prbe_pkg.sv
// Shared types, constants and the colour reduction for the run encoder.
// No dependencies; every module imports this package.
`timescale 1ns / 1ps

package prbe_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int ENTRY_W  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   localparam int COLOR_W  = 24;
   localparam int CHAN_W   = 8;
   localparam int LEN_W    = 15;
   localparam int C14_W    = 14;
   localparam int INDEX_W  = 8;
   localparam int WORD_W   = 32;
   localparam int BYTES_W  = 3;
   localparam int PFX_W    = 3;

   // Palette search tree: groups of sixteen lanes, then one pick across groups.
   localparam int GROUP_SIZE = 16;
   localparam int GROUP_W    = 4;
   localparam int GROUPS     = (PALETTE_ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;

   localparam logic [INDEX_W:0] ENTRIES_LIMIT = (INDEX_W + 1)'(PALETTE_ENTRIES);

   localparam logic [PFX_W-1:0] PFX_LONG    = 3'b111;
   localparam logic [PFX_W-1:0] PFX_DIRECT  = 3'b110;
   localparam logic [PFX_W-1:0] PFX_INDEXED = 3'b101;
   localparam logic [PFX_W-1:0] PFX_ABOVE   = 3'b100;

   localparam logic [BYTES_W-1:0] BYTES_ACK     = 3'd0;
   localparam logic [BYTES_W-1:0] BYTES_ABOVE   = 3'd1;
   localparam logic [BYTES_W-1:0] BYTES_INDEXED = 3'd2;
   localparam logic [BYTES_W-1:0] BYTES_DIRECT  = 3'd3;
   localparam logic [BYTES_W-1:0] BYTES_LONG    = 3'd4;

   localparam logic [LEN_W-1:0] LONG_LIMIT  = 15'd127;
   localparam logic [LEN_W-1:0] SHORT_LIMIT = 15'd31;
   localparam logic [LEN_W-1:0] LEN_ONE     = 15'd1;

   // red / 17 as (red * 241) >> 12, exact over 0..255
   localparam logic [CHAN_W-1:0] RED_RECIP = 8'd241;

   typedef enum logic {
      OP_RUN   = 1'b0,
      OP_WRITE = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      FORM_WRITE,
      FORM_LONG,
      FORM_ABOVE,
      FORM_DIRECT,
      FORM_LOOKUP
   } form_type;

   typedef struct packed {
      logic               wr_en;
      logic [ENTRY_W-1:0] wr_index;
      logic [COLOR_W-1:0] wr_color;
      logic               wr_valid;
      logic               cmp_load;
   } cam_ctl_type;

   typedef struct packed {
      logic [GROUPS-1:0]              hit;
      logic [GROUPS-1:0][GROUP_W-1:0] lane;
   } grp_sum_type;

   function automatic logic [C14_W-1:0] colour14(input logic [CHAN_W-1:0] red,
                                                 input logic [CHAN_W-1:0] green,
                                                 input logic [CHAN_W-1:0] blue);
      logic [2*CHAN_W-1:0] prod;
      prod = {{CHAN_W{1'b0}}, red} * {{CHAN_W{1'b0}}, RED_RECIP};
      return {prod[2*CHAN_W-1:2*CHAN_W-4], green[CHAN_W-1:3], blue[CHAN_W-1:3]};
   endfunction

endpackage

// File: rtl/prbe_cam.sv
// Palette store with a parallel exact-colour compare, match vector registered.
// Depends on prbe_pkg.
`timescale 1ns / 1ps

module prbe_cam (
   input  logic                                  clock,
   input  logic                                  reset,
   input  prbe_pkg::cam_ctl_type                 ctl,
   input  logic [prbe_pkg::COLOR_W-1:0]          cmp_color,
   output logic [prbe_pkg::PALETTE_ENTRIES-1:0]  match_ff
);
   import prbe_pkg::*;

   logic [COLOR_W-1:0]         colors_ff [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] valid_ff;
   logic [PALETTE_ENTRIES-1:0] valid_in;
   logic [PALETTE_ENTRIES-1:0] match_in;

   always_comb begin
      valid_in = valid_ff;
      if (ctl.wr_en) begin
         valid_in[ctl.wr_index] = ctl.wr_valid;
      end
      for (int i = 0; i < PALETTE_ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (colors_ff[i] == cmp_color);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         colors_ff[ctl.wr_index] <= ctl.wr_color;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.cmp_load) begin
         match_ff <= match_in;
      end
   end

endmodule

// File: rtl/prbe_prio.sv
// Lowest-index priority encoder over the match vector: registered group
// stage, then a pick across groups. Depends on prbe_pkg.
`timescale 1ns / 1ps

module prbe_prio (
   input  logic                                 clock,
   input  logic                                 load,
   input  logic [prbe_pkg::PALETTE_ENTRIES-1:0] match,
   output logic                                 hit,
   output logic [prbe_pkg::INDEX_W-1:0]         index
);
   import prbe_pkg::*;

   grp_sum_type grp_ff;
   grp_sum_type grp_in;

   always_comb begin
      grp_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         // scan downwards so the lowest lane wins
         for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
            if ((g * GROUP_SIZE + j) < PALETTE_ENTRIES) begin
               if (match[g * GROUP_SIZE + j]) begin
                  grp_in.hit[g]  = 1'b1;
                  grp_in.lane[g] = GROUP_W'(j);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         grp_ff <= grp_in;
      end
   end

   always_comb begin
      hit   = 1'b0;
      index = '0;
      for (int g = GROUPS - 1; g >= 0; g--) begin
         if (grp_ff.hit[g]) begin
            hit   = 1'b1;
            index = INDEX_W'(g * GROUP_SIZE) | INDEX_W'(grp_ff.lane[g]);
         end
      end
   end

endmodule

// File: rtl/pixel_run_block_encoder.sv
// Pixel run block encoder: classify run, palette compare, encode, output beat.
// An accepted beat passes stages 1, 2 and 3 and the output register to rsp_valid;
// one beat per cycle, input stalls come only from rsp_stall.
// The palette path sets the staging: 256-way compare, group priority
// encode and final pick each sit in a stage of their own.
// Reset clears the pipeline valid bits and all palette valid bits.
`timescale 1ns / 1ps

module pixel_run_block_encoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [prbe_pkg::CHAN_W-1:0]   req_red,
   input  logic [prbe_pkg::CHAN_W-1:0]   req_green,
   input  logic [prbe_pkg::CHAN_W-1:0]   req_blue,
   input  logic [prbe_pkg::LEN_W-1:0]    req_run_length,
   input  logic                          req_above_flag,
   input  logic [prbe_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic                          req_entry_valid,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [prbe_pkg::WORD_W-1:0]   rsp_code_word,
   output logic [prbe_pkg::BYTES_W-1:0]  rsp_code_bytes
);
   import prbe_pkg::*;

   // stage 1: captured beat
   logic               s1_valid_ff, s1_valid_in;
   logic               s1_op_ff, s1_op_in;
   logic [COLOR_W-1:0] s1_rgb_ff, s1_rgb_in;
   logic [LEN_W-1:0]   s1_len_ff, s1_len_in;
   logic               s1_flag_ff, s1_flag_in;
   logic [INDEX_W-1:0] s1_idx_ff, s1_idx_in;
   logic               s1_ev_ff, s1_ev_in;

   // stage 2: classified, match vector in the palette
   logic               s2_valid_ff, s2_valid_in;
   form_type           s2_form_ff, s2_form_in;
   logic [LEN_W-1:0]   s2_n_ff, s2_n_in;
   logic [C14_W-1:0]   s2_c14_ff, s2_c14_in;

   // stage 3: group hits in the priority encoder
   logic               s3_valid_ff, s3_valid_in;
   form_type           s3_form_ff, s3_form_in;
   logic [LEN_W-1:0]   s3_n_ff, s3_n_in;
   logic [C14_W-1:0]   s3_c14_ff, s3_c14_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   logic [WORD_W-1:0]  out_word_ff, out_word_in;
   logic [BYTES_W-1:0] out_bytes_ff, out_bytes_in;

   logic out_free, s3_free, s2_free, s1_free;
   logic [LEN_W-1:0] s1_n;
   logic [C14_W-1:0] s1_c14;
   form_type         s1_form;
   cam_ctl_type      cam_ctl;
   logic [PALETTE_ENTRIES-1:0] match;
   logic             pal_hit;
   logic [INDEX_W-1:0] pal_index;

   // a stage loads when empty or when the stage after it moves on
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s3_free   = !s3_valid_ff || out_free;
   assign s2_free   = !s2_valid_ff || s3_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_stall = !s1_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_op_in    = s1_op_ff;
      s1_rgb_in   = s1_rgb_ff;
      s1_len_in   = s1_len_ff;
      s1_flag_in  = s1_flag_ff;
      s1_idx_in   = s1_idx_ff;
      s1_ev_in    = s1_ev_ff;
      if (s1_free) begin
         s1_valid_in = req_valid;
         s1_op_in    = req_opcode;
         s1_rgb_in   = {req_red, req_green, req_blue};
         s1_len_in   = req_run_length;
         s1_flag_in  = req_above_flag;
         s1_idx_in   = req_entry_index;
         s1_ev_in    = req_entry_valid;
      end
   end

   // classify the run; a zero length wraps to the long form
   always_comb begin
      s1_n   = s1_len_ff - LEN_ONE;
      s1_c14 = colour14(s1_rgb_ff[23:16], s1_rgb_ff[15:8], s1_rgb_ff[7:0]);
      if (s1_op_ff == OP_WRITE) begin
         s1_form = FORM_WRITE;
      end else if (s1_n > LONG_LIMIT) begin
         s1_form = FORM_LONG;
      end else if (s1_flag_ff && (s1_n <= SHORT_LIMIT)) begin
         s1_form = FORM_ABOVE;
      end else if (s1_n > SHORT_LIMIT) begin
         s1_form = FORM_DIRECT;
      end else begin
         s1_form = FORM_LOOKUP;
      end
   end

   // palette write lands as the beat leaves stage 1, so later runs see it
   always_comb begin
      cam_ctl.wr_en    = s1_valid_ff && s2_free && (s1_op_ff == OP_WRITE) &&
                         ({1'b0, s1_idx_ff} < ENTRIES_LIMIT);
      cam_ctl.wr_index = s1_idx_ff[ENTRY_W-1:0];
      cam_ctl.wr_color = s1_rgb_ff;
      cam_ctl.wr_valid = s1_ev_ff;
      cam_ctl.cmp_load = s2_free;
   end

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_form_in  = s2_form_ff;
      s2_n_in     = s2_n_ff;
      s2_c14_in   = s2_c14_ff;
      if (s2_free) begin
         s2_valid_in = s1_valid_ff;
         s2_form_in  = s1_form;
         s2_n_in     = s1_n;
         s2_c14_in   = s1_c14;
      end
   end

   always_comb begin
      s3_valid_in = s3_valid_ff;
      s3_form_in  = s3_form_ff;
      s3_n_in     = s3_n_ff;
      s3_c14_in   = s3_c14_ff;
      if (s3_free) begin
         s3_valid_in = s2_valid_ff;
         s3_form_in  = s2_form_ff;
         s3_n_in     = s2_n_ff;
         s3_c14_in   = s2_c14_ff;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      out_bytes_in = out_bytes_ff;
      if (out_free) begin
         out_valid_in = s3_valid_ff;
         unique case (s3_form_ff)
            FORM_WRITE: begin
               out_word_in  = '0;
               out_bytes_in = BYTES_ACK;
            end
            FORM_LONG: begin
               out_word_in  = {PFX_LONG, s3_n_ff, s3_c14_ff};
               out_bytes_in = BYTES_LONG;
            end
            FORM_ABOVE: begin
               out_word_in  = {PFX_ABOVE, s3_n_ff[4:0], 24'h0};
               out_bytes_in = BYTES_ABOVE;
            end
            FORM_LOOKUP: begin
               if (pal_hit) begin
                  out_word_in  = {PFX_INDEXED, s3_n_ff[4:0], pal_index, 16'h0};
                  out_bytes_in = BYTES_INDEXED;
               end else begin
                  out_word_in  = {PFX_DIRECT, s3_n_ff[6:0], s3_c14_ff, 8'h0};
                  out_bytes_in = BYTES_DIRECT;
               end
            end
            default: begin
               out_word_in  = {PFX_DIRECT, s3_n_ff[6:0], s3_c14_ff, 8'h0};
               out_bytes_in = BYTES_DIRECT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff     <= s1_op_in;
      s1_rgb_ff    <= s1_rgb_in;
      s1_len_ff    <= s1_len_in;
      s1_flag_ff   <= s1_flag_in;
      s1_idx_ff    <= s1_idx_in;
      s1_ev_ff     <= s1_ev_in;
      s2_form_ff   <= s2_form_in;
      s2_n_ff      <= s2_n_in;
      s2_c14_ff    <= s2_c14_in;
      s3_form_ff   <= s3_form_in;
      s3_n_ff      <= s3_n_in;
      s3_c14_ff    <= s3_c14_in;
      out_word_ff  <= out_word_in;
      out_bytes_ff <= out_bytes_in;
   end

   prbe_cam u_cam (
      .clock     (clock),
      .reset     (reset),
      .ctl       (cam_ctl),
      .cmp_color (s1_rgb_ff),
      .match_ff  (match)
   );

   prbe_prio u_prio (
      .clock (clock),
      .load  (s3_free),
      .match (match),
      .hit   (pal_hit),
      .index (pal_index)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_word  = out_word_ff;
   assign rsp_code_bytes = out_bytes_ff;

endmodule

// File: rtl/prbe_checker.sv
// Port-level checks on the encoder's result beats, bound to the top level.
// Depends on prbe_pkg and pixel_run_block_encoder_assert.svh.
`timescale 1ns / 1ps
`include "pixel_run_block_encoder_assert.svh"

module prbe_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [prbe_pkg::WORD_W-1:0]   rsp_code_word,
   input logic [prbe_pkg::BYTES_W-1:0]  rsp_code_bytes
);
   import prbe_pkg::*;

   // hold a stalled beat
   `PRBE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_code_word) && $stable(rsp_code_bytes))
   `PRBE_ASSERT_NOW(a_bytes_range, clock, reset, rsp_valid, rsp_code_bytes <= BYTES_LONG)
   `PRBE_ASSERT_NOW(a_ack_empty, clock, reset, rsp_valid && (rsp_code_bytes == BYTES_ACK), rsp_code_word == '0)
   `PRBE_ASSERT_NOW(a_long_prefix, clock, reset, rsp_valid && (rsp_code_bytes == BYTES_LONG), rsp_code_word[31:29] == PFX_LONG)
   `PRBE_ASSERT_NOW(a_indexed_form, clock, reset, rsp_valid && (rsp_code_bytes == BYTES_INDEXED), (rsp_code_word[31:29] == PFX_INDEXED) && (rsp_code_word[15:0] == 16'h0))

endmodule

bind pixel_run_block_encoder prbe_checker u_prbe_checker (.*);
